/* hw/rtl/srtc_pkg.sv */
// Package for the SRAM region table checker: payload structs, table entry,
// status codes, control/status structs and sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package srtc_pkg;

   localparam int MAX_REGIONS = 32;
   localparam int SRAM_BYTES  = 1048576;

   // table index and fill count widths
   localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W = $clog2(MAX_REGIONS + 1);

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // result status codes
   localparam logic [3:0] ST_ADDED     = 4'd0;
   localparam logic [3:0] ST_DUP_SAME  = 4'd1;
   localparam logic [3:0] ST_LOCKED    = 4'd2;
   localparam logic [3:0] ST_DUP_DIFF  = 4'd3;
   localparam logic [3:0] ST_NEG_ID    = 4'd4;
   localparam logic [3:0] ST_BAD_BOUND = 4'd5;
   localparam logic [3:0] ST_MISALIGN  = 4'd6;
   localparam logic [3:0] ST_BEYOND    = 4'd7;
   localparam logic [3:0] ST_OVERLAP   = 4'd8;
   localparam logic [3:0] ST_FULL      = 4'd9;

   typedef struct packed {
      logic signed [15:0] decl_id;
      logic signed [31:0] region_offset;
      logic signed [31:0] decl_len;
      logic signed [31:0] region_alignment;
      logic               preloaded;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [14:0] clash_id;
   } rsp_type;

   typedef struct packed {
      logic [14:0] id;
      logic [31:0] offset;
      logic [31:0] size;
      logic [31:0] alignment;
      logic        preloaded;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // controller -> datapath
   typedef struct packed {
      logic start;     // latch request, reset remainder unit and scan
      logic div_step;  // one restoring division step
      logic scan_step; // advance table scan
      logic finish;    // load result register, append entry if added
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_last;
      logic scan_done;
      logic out_free;
   } sts_type;

endpackage

/* hw/rtl/srtc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module srtc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/srtc_ctrl.sv */
// Controller state machine of the region table checker.
// Depends on srtc_pkg.
`timescale 1ns / 1ps

module srtc_ctrl
   import srtc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DIV    = 4'b0010,
      S_SCAN   = 4'b0100,
      S_DECIDE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // hold until the result register can take the transfer
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

/* hw/rtl/srtc_dpath.sv */
// Datapath of the region table checker: request register, remainder unit,
// table scan with duplicate/overlap tracking, verdict and result register.
// Depends on srtc_pkg and srtc_ram.
`timescale 1ns / 1ps

module srtc_dpath
   import srtc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  logic    csr_valid,
   input  logic    csr_data,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  cmd_type cmd,
   output sts_type sts
);

   req_type              req_ff;
   logic                 locked_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [32:0]          rem_ff, rem_in;
   logic [31:0]          dvd_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [CNT_W-1:0]     rd_idx_ff;
   logic                 cmp_valid_ff;
   logic                 dup_hit_ff, dup_same_ff;
   logic                 ovl_hit_ff;
   logic [14:0]          ovl_id_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   entry_type            rd_entry;
   entry_type            wr_entry;
   logic [ENTRY_W-1:0]   rd_bits;
   logic                 rd_issue;
   logic                 wr_en;
   logic [32:0]          shifted;
   logic [32:0]          new_end, old_end;
   logic                 id_neg, id_match, fields_match, overlap;
   logic                 bad_bound, beyond;
   logic [3:0]           verdict;

   // ---- remainder unit: restoring, one quotient bit a cycle
   assign shifted = {rem_ff[31:0], dvd_ff[31]};
   always_comb begin
      if (shifted >= {1'b0, req_ff.region_alignment}) begin
         rem_in = shifted - {1'b0, req_ff.region_alignment};
      end else begin
         rem_in = shifted;
      end
   end

   // ---- table scan
   assign rd_issue = cmd.scan_step && (rd_idx_ff < count_ff);
   assign rd_entry = entry_type'(rd_bits);

   assign id_neg   = req_ff.decl_id[15];
   assign id_match = !id_neg && (rd_entry.id == req_ff.decl_id[14:0]);
   assign fields_match = (rd_entry.offset == req_ff.region_offset) &&
                         (rd_entry.size == req_ff.decl_len) &&
                         (rd_entry.alignment == req_ff.region_alignment) &&
                         (rd_entry.preloaded == req_ff.preloaded);

   assign new_end = {1'b0, req_ff.region_offset} + {1'b0, req_ff.decl_len};
   assign old_end = {1'b0, rd_entry.offset} + {1'b0, rd_entry.size};
   assign overlap = ({1'b0, req_ff.region_offset} < old_end) &&
                    ({1'b0, rd_entry.offset} < new_end);

   // ---- verdict
   assign bad_bound = req_ff.region_offset[31] || req_ff.decl_len[31] ||
                      (req_ff.decl_len == '0) || req_ff.region_alignment[31] ||
                      (req_ff.region_alignment == '0);
   assign beyond    = new_end > 33'(SRAM_BYTES);

   always_comb begin
      if (locked_ff) begin
         verdict = ST_LOCKED;
      end else if (dup_hit_ff) begin
         verdict = dup_same_ff ? ST_DUP_SAME : ST_DUP_DIFF;
      end else if (id_neg) begin
         verdict = ST_NEG_ID;
      end else if (bad_bound) begin
         verdict = ST_BAD_BOUND;
      end else if (rem_ff != '0) begin
         verdict = ST_MISALIGN;
      end else if (beyond) begin
         verdict = ST_BEYOND;
      end else if (ovl_hit_ff) begin
         verdict = ST_OVERLAP;
      end else if (count_ff == CNT_W'(MAX_REGIONS)) begin
         verdict = ST_FULL;
      end else begin
         verdict = ST_ADDED;
      end
   end

   assign wr_en = cmd.finish && (verdict == ST_ADDED);
   assign wr_entry = '{id: req_ff.decl_id[14:0], offset: req_ff.region_offset,
                       size: req_ff.decl_len, alignment: req_ff.region_alignment,
                       preloaded: req_ff.preloaded};

   srtc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_REGIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_issue),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_bits)
   );

   // ---- payload registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_ff <= req_data;
         rem_ff <= '0;
         dvd_ff <= req_data.region_offset;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[30:0], 1'b0};
      end
      if (cmd.start) begin
         dup_same_ff <= 1'b0;
         ovl_id_ff   <= '0;
      end else if (cmp_valid_ff) begin
         if (id_match) begin
            dup_same_ff <= fields_match;
         end
         if (overlap && !ovl_hit_ff) begin
            ovl_id_ff <= rd_entry.id;
         end
      end
      if (cmd.finish) begin
         rsp_ff.status   <= verdict;
         rsp_ff.clash_id <= (verdict == ST_OVERLAP) ? ovl_id_ff : '0;
      end
   end

   // ---- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff    <= 1'b0;
         count_ff     <= '0;
         div_cnt_ff   <= '0;
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
         dup_hit_ff   <= 1'b0;
         ovl_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            locked_ff <= csr_data;
         end
         if (cmd.start) begin
            div_cnt_ff <= '0;
            rd_idx_ff  <= '0;
            dup_hit_ff <= 1'b0;
            ovl_hit_ff <= 1'b0;
         end else begin
            if (cmd.div_step) begin
               div_cnt_ff <= div_cnt_ff + 1'b1;
            end
            if (rd_issue) begin
               rd_idx_ff <= rd_idx_ff + 1'b1;
            end
            if (cmp_valid_ff) begin
               dup_hit_ff <= dup_hit_ff || id_match;
               ovl_hit_ff <= ovl_hit_ff || overlap;
            end
         end
         cmp_valid_ff <= rd_issue;
         if (wr_en) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.div_last  = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign sts.scan_done = (rd_idx_ff == count_ff) && !cmp_valid_ff;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/sram_region_table_checker_core.sv */
// Top level of the SRAM region table checker.
// Depends on srtc_pkg, srtc_ctrl, srtc_dpath (and srtc_ram below it).
//
//   channel  ports                          direction  carries
//   req      req_valid/req_stall/req_data   in         one region declaration
//   rsp      rsp_valid/rsp_stall/rsp_data   out        status and clash id
//   csr      csr_valid/csr_ready/csr_data   in         graph_locked bit
//
// Sequence: one item at a time; an item passes an accept step, the
//   restoring remainder unit (offset mod alignment), the table scan through
//   the single registered read port (over the N entries stored, up to 32)
//   and a decide step.
// Reset: synchronous, active high; clears the lock bit and the fill count.
//   The table itself is never cleared: only entries below the fill count
//   are read.
// Stalls: a result waits in the output register while rsp_stall is high;
//   the next item is accepted meanwhile and holds in its decide step
//   until that register frees up.
`timescale 1ns / 1ps

module sram_region_table_checker_core
   import srtc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   // declaration input
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // result output
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   // lock register write
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   cmd_type cmd;
   sts_type sts;

   // sequencing: idle -> remainder -> scan -> decide
   srtc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // table, remainder unit, checks and the result register
   srtc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

   // the lock bit is a plain flop: take a write transfer in any cycle
   assign csr_ready = 1'b1;

endmodule

/* hw/rtl/srtc_checker.sv */
// Port-level checks for the SRAM region table checker, bound to its top.
// Depends on srtc_pkg and sram_region_table_checker_core.
`timescale 1ns / 1ps

module srtc_checker
   import srtc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a result waiting on a stall holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // one item in flight: no transfer right after a transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   // the remainder unit runs before any verdict, so no result rises shortly after a request
   a_no_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##2 !$rose(rsp_valid))
      else $error("result appeared too soon after a request");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_FULL)
      else $error("status code out of range");

   a_clash_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_OVERLAP) |-> rsp_data.clash_id == '0)
      else $error("clash id set without overlap");

endmodule

bind sram_region_table_checker_core srtc_checker u_srtc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
